// ----- rtl/serial_mul_div_unit_assert.svh -----
// Assertion macros used by the serial multiply/divide unit RTL.
`ifndef SERIAL_MUL_DIV_UNIT_ASSERT_SVH
`define SERIAL_MUL_DIV_UNIT_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define SMDU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("smdu assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define SMDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("smdu assertion failed");

`endif

// ----- rtl/smdu_pkg.sv -----
// Types, command codes and step counts for the serial multiply/divide unit.
package smdu_pkg;

    localparam logic [1:0] CMD_STEP = 2'd0;
    localparam logic [1:0] CMD_MUL  = 2'd1;
    localparam logic [1:0] CMD_DIV  = 2'd2;

    localparam logic [3:0] MUL_STEPS = 4'd8;
    localparam logic [4:0] DIV_STEPS = 5'd16;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] operand_a;
        logic [7:0]  operand_b;
    } t_in;

    typedef struct packed {
        logic [15:0] product_or_remainder;
        logic [15:0] quotient_or_shifted;
        logic        busy_res;
    } t_out;

    typedef struct packed {
        logic [3:0]  mul_count;
        logic [4:0]  div_count;
        logic [15:0] accumulator;
        logic [15:0] shift_register;
        logic [23:0] shifted_operand;
    } t_state;

endpackage

// ----- rtl/serial_mul_div_unit.sv -----
// Top level of the serial multiply/divide unit: input register, state, result register.
//
//  channel | valid      | stall       | word
//  --------+------------+-------------+-----------
//  in      | i_in_valid | o_in_stall  | i_in_data
//  out     | o_out_valid| i_out_stall | o_out_data
//
// The accepting edge loads a word into the input register; from there it passes through the
// step logic into the state and result registers once the result slot is free or draining.
// A new word is accepted every cycle while the output is not stalled; the state loop is one
// register deep. Reset clears the step counters, state and valid flags; no clearing pass.
// A stall on the output holds the result and backs up through the input register.
`include "serial_mul_div_unit_assert.svh"

module serial_mul_div_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  smdu_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output smdu_pkg::t_out   o_out_data
);

    logic             r_in_valid;
    smdu_pkg::t_in    r_in;
    smdu_pkg::t_state r_state;
    smdu_pkg::t_state n_state;
    logic             r_out_valid;
    smdu_pkg::t_out   r_out;
    logic             s_fire;
    logic             s_mul_start;
    logic             s_div_start;
    logic             s_state_busy;

    // advance the step stage when the result slot is free or draining
    assign s_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !s_fire;

    assign s_mul_start  = s_fire && (r_in.cmd == smdu_pkg::CMD_MUL);
    assign s_div_start  = s_fire && (r_in.cmd == smdu_pkg::CMD_DIV);
    assign s_state_busy = (r_state.mul_count != 4'd0) || (r_state.div_count != 5'd0);

    smdu_step u_step (
        .i_cmd_word (r_in),
        .i_state    (r_state),
        .o_state    (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (s_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (s_fire) begin
            r_out.product_or_remainder <= n_state.accumulator;
            r_out.quotient_or_shifted  <= n_state.shift_register;
            r_out.busy_res             <= (n_state.mul_count != 4'd0)
                                       || (n_state.div_count != 5'd0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SMDU_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !s_fire, $stable(r_state))
    `SMDU_ASSERT_NEXT(a_mul_start, i_clk, i_rst_n, s_mul_start, r_state.mul_count == 4'd8)
    `SMDU_ASSERT_NEXT(a_mul_clear, i_clk, i_rst_n, s_mul_start, r_state.accumulator == 16'd0)
    `SMDU_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, s_div_start, r_state.div_count == 5'd16)
    `SMDU_ASSERT_NOW(a_busy_match, i_clk, i_rst_n, r_out_valid, r_out.busy_res == s_state_busy)

endmodule

// ----- rtl/smdu_step.sv -----
// Next-state logic: command decode, one multiply step and one divide step.
module smdu_step (
    input  smdu_pkg::t_in    i_cmd_word,
    input  smdu_pkg::t_state i_state,
    output smdu_pkg::t_state o_state
);

    smdu_pkg::t_state s_mul;
    smdu_pkg::t_state s_div;
    logic [23:0]      s_sop_shr;

    always_comb begin
        s_mul     = i_state;
        s_div     = i_state;
        s_sop_shr = 24'd0;
        o_state   = i_state;

        unique case (i_cmd_word.cmd)
            smdu_pkg::CMD_STEP: begin
                // multiply step first
                if (i_state.mul_count != 4'd0) begin
                    s_mul.mul_count = i_state.mul_count - 4'd1;
                    if (i_state.shift_register[0]) begin
                        s_mul.accumulator = i_state.accumulator
                                          + i_state.shifted_operand[15:0];
                    end
                    s_mul.shift_register  = {1'b0, i_state.shift_register[15:1]};
                    s_mul.shifted_operand = {i_state.shifted_operand[22:0], 1'b0};
                end
                // then divide step on the multiply result
                s_div = s_mul;
                if (s_mul.div_count != 5'd0) begin
                    s_div.div_count      = s_mul.div_count - 5'd1;
                    s_sop_shr            = {1'b0, s_mul.shifted_operand[23:1]};
                    s_div.shifted_operand = s_sop_shr;
                    s_div.shift_register = {s_mul.shift_register[14:0], 1'b0};
                    if ({8'd0, s_mul.accumulator} >= s_sop_shr) begin
                        // divisor fits, so it is below 2^16
                        s_div.accumulator       = s_mul.accumulator - s_sop_shr[15:0];
                        s_div.shift_register[0] = 1'b1;
                    end
                end
                o_state = s_div;
            end
            smdu_pkg::CMD_MUL: begin
                o_state.accumulator     = 16'd0;
                o_state.shift_register  = {i_cmd_word.operand_b,
                                           i_cmd_word.operand_a[7:0]};
                o_state.shifted_operand = {16'd0, i_cmd_word.operand_b};
                o_state.mul_count       = smdu_pkg::MUL_STEPS;
            end
            smdu_pkg::CMD_DIV: begin
                o_state.accumulator     = i_cmd_word.operand_a;
                o_state.shifted_operand = {i_cmd_word.operand_b, 16'd0};
                o_state.div_count       = smdu_pkg::DIV_STEPS;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ----- tb/smdu_checker.sv -----
// Checker for the serial multiply/divide unit: predicts every result word and compares it.
`timescale 1ns / 1ps

module smdu_checker
    import smdu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending
);

    // Own copy of the unit's state
    logic [3:0]  mul_left;
    logic [4:0]  div_left;
    logic [15:0] acc;
    logic [15:0] shift_reg;
    logic [23:0] shifted_opnd;

    t_out result_q[$];
    t_out want;

    function automatic t_out predict_word(input t_in w);
        t_out r;
        case (w.cmd)
            CMD_STEP: begin
                // Multiplier advances first, then the divider on the updated registers
                if (mul_left != '0) begin
                    mul_left = mul_left - 4'd1;
                    if (shift_reg[0])
                        acc = acc + shifted_opnd[15:0];
                    shift_reg    = shift_reg >> 1;
                    shifted_opnd = shifted_opnd << 1;
                end
                if (div_left != '0) begin
                    div_left     = div_left - 5'd1;
                    shift_reg    = shift_reg << 1;
                    shifted_opnd = shifted_opnd >> 1;
                    if ({8'h00, acc} >= shifted_opnd) begin
                        acc          = acc - shifted_opnd[15:0];
                        shift_reg[0] = 1'b1;
                    end
                end
            end
            CMD_MUL: begin
                acc          = '0;
                shift_reg    = {w.operand_b, w.operand_a[7:0]};
                shifted_opnd = {16'h0000, w.operand_b};
                mul_left     = MUL_STEPS;
            end
            CMD_DIV: begin
                acc          = w.operand_a;
                shifted_opnd = {w.operand_b, 16'h0000};
                div_left     = DIV_STEPS;
            end
            default: ;
        endcase
        r.product_or_remainder = acc;
        r.quotient_or_shifted  = shift_reg;
        r.busy_res             = (mul_left != '0) || (div_left != '0);
        return r;
    endfunction

    task automatic log_failure(input string msg);
        o_errors++;
        if (o_errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mul_left     = '0;
            div_left     = '0;
            acc          = '0;
            shift_reg    = '0;
            shifted_opnd = '0;
            result_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                result_q.push_back(predict_word(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    log_failure($sformatf("unexpected word acc=%h sreg=%h busy=%b",
                        i_out_data.product_or_remainder, i_out_data.quotient_or_shifted,
                        i_out_data.busy_res));
                end else begin
                    want = result_q.pop_front();
                    if (i_out_data.product_or_remainder !== want.product_or_remainder ||
                        i_out_data.quotient_or_shifted !== want.quotient_or_shifted ||
                        i_out_data.busy_res !== want.busy_res)
                        log_failure($sformatf(
                            "mismatch: expected acc=%h sreg=%h busy=%b, got acc=%h sreg=%h busy=%b",
                            want.product_or_remainder, want.quotient_or_shifted, want.busy_res,
                            i_out_data.product_or_remainder, i_out_data.quotient_or_shifted,
                            i_out_data.busy_res));
                end
            end
        end
        o_pending = result_q.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the serial multiply/divide unit: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
    import smdu_pkg::*;

    localparam logic [1:0] CMD_NOP   = 2'd3;   // unused code, only reports the state
    localparam int RANDOM_WORDS      = 1400;
    localparam int QUIET_LIMIT       = 2000;
    localparam int DRAIN_CYCLES      = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall;
    t_out out_data;

    int errors;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    int words_sent;
    int phase_base;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    serial_mul_div_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    smdu_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Abort when no word moves on either channel for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic logic [15:0] pick_a();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_b();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [1:0] c, input logic [15:0] a, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{cmd: c, operand_a: a, operand_b: b};
        do @(posedge clk); while (in_stall);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic run_steps(input int n);
        repeat (n) send_word(CMD_STEP, 16'($urandom), 8'($urandom));
    endtask

    task automatic run_sequence();
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                send_word(CMD_MUL, pick_a(), pick_b());
                run_steps(($urandom_range(3) == 0) ? $urandom_range(0, 7) : 8 + $urandom_range(2));
            end
            4, 5, 6: begin
                send_word(CMD_DIV, pick_a(), pick_b());
                run_steps(($urandom_range(3) == 0) ? $urandom_range(0, 15) : 16 + $urandom_range(2));
            end
            7: begin
                send_word(CMD_MUL, pick_a(), pick_b());
                run_steps($urandom_range(0, 8));
                send_word(CMD_DIV, pick_a(), pick_b());
                run_steps(16);
            end
            8: begin
                send_word(CMD_DIV, pick_a(), pick_b());
                run_steps($urandom_range(0, 16));
                send_word(CMD_MUL, pick_a(), pick_b());
                run_steps(16);
            end
            default: begin
                repeat ($urandom_range(1, 4))
                    send_word(2'($urandom_range(3)), pick_a(), pick_b());
            end
        endcase
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_stall     = 1'b0;
        quiet_cycles  = 0;
        words_sent    = 0;
        send_idle_pct = 17;
        recv_idle_pct = 51;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: idle step, unused code, restart while busy, divide by zero over a multiply
        send_word(CMD_STEP, 16'hFFFF, 8'hFF);
        send_word(CMD_NOP, 16'h0000, 8'h00);
        send_word(CMD_MUL, 16'hA5FF, 8'hFF);
        run_steps(3);
        send_word(CMD_MUL, 16'h0080, 8'h01);
        send_word(CMD_DIV, 16'hFFFF, 8'h00);
        run_steps(16);
        send_word(CMD_NOP, 16'hFFFF, 8'hFF);

        phase_base = words_sent;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 17 : 0;
            while (words_sent < phase_base + (phase + 1) * RANDOM_WORDS / 3)
                run_sequence();
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
